// ----- design/ubt_pkg.sv -----
// Shared types, codes and defaults for the unordered bag table.
`default_nettype none

package ubt_pkg;

   // Default sizes of the table.
   localparam int CAPACITY_DEF  = 16;
   localparam int KEY_BITS_DEF  = 32;
   localparam int DATA_BITS_DEF = 32;

   // Fixed widths of the item fields.
   localparam int MODE_W   = 3;
   localparam int FIELD_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd3;

   // Input item.
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FIELD_W-1:0] key_in;
      logic [FIELD_W-1:0] data_in;
      logic [SLOT_W-1:0]  slot_in;
   } ubt_req_type;

   // Result item.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_out;
      logic [FIELD_W-1:0]  key_out;
      logic [FIELD_W-1:0]  data_out;
      logic [COUNT_W-1:0]  entry_count;
   } ubt_rsp_type;

   // Which result the datapath builds.
   typedef enum logic [2:0] {
      RES_CLEAN = 3'd0,
      RES_ADD   = 3'd1,
      RES_FULL  = 3'd2,
      RES_MISS  = 3'd3,
      RES_BAD   = 3'd4,
      RES_HIT   = 3'd5,
      RES_READ  = 3'd6
   } ubt_res_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             capture;
      logic             add_entry;
      logic             clear_all;
      logic             scan_start;
      logic             scan_step;
      logic             fetch_last;
      logic             fetch_slot;
      logic             move_entry;
      logic             set_res;
      ubt_res_kind_type res_kind;
      logic             load_rsp;
   } ubt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_add;
      logic is_find;
      logic is_delete;
      logic is_clear;
      logic is_read;
      logic full;
      logic empty;
      logic slot_bad;
      logic scan_hit;
      logic scan_last;
      logic rsp_free;
   } ubt_stat_type;

endpackage

`default_nettype wire

// ----- design/unordered_bag_table_unit.sv -----
// Top level of the unordered bag table: controller and datapath.
//
//   Channel | Ports                             | Moves
//   --------+-----------------------------------+----------------------------------
//   request | req_valid, req_ready, req_payload | one operation item in
//   result  | rsp_valid, rsp_ready, rsp_payload | one result item out per request
//
// Add, clear, unused modes, and a delete or read with a bad slot go from the execute
// state to the finish state, where the result register loads; a good delete or read
// also passes the fetch state. Find walks the entry memory one slot per cycle through
// its single read port up to a hit or the last entry. The next item is accepted
// in the cycle after that load at the earliest, even while the previous result waits
// in the output register; a stalled result holds the controller before the next load.
// Reset clears the count and the control state; memory contents are kept.
`default_nettype none

module unordered_bag_table_unit #(
   parameter int CAPACITY  = ubt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS  = ubt_pkg::KEY_BITS_DEF,
   parameter int DATA_BITS = ubt_pkg::DATA_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  ubt_pkg::ubt_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ubt_pkg::ubt_rsp_type rsp_payload
);

   ubt_pkg::ubt_cmd_type  cmd;
   ubt_pkg::ubt_stat_type stat;

   // Sequencer.
   ubt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and result path.
   ubt_dpath #(
      .CAPACITY  (CAPACITY),
      .KEY_BITS  (KEY_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- design/ubt_dpath.sv -----
// Datapath of the unordered bag table: entry memory, count, scan index and result registers.
`default_nettype none

module ubt_dpath #(
   parameter int CAPACITY  = ubt_pkg::CAPACITY_DEF,
   parameter int KEY_BITS  = ubt_pkg::KEY_BITS_DEF,
   parameter int DATA_BITS = ubt_pkg::DATA_BITS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  ubt_pkg::ubt_cmd_type cmd,
   output ubt_pkg::ubt_stat_type stat,
   input  ubt_pkg::ubt_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output ubt_pkg::ubt_rsp_type rsp_payload
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > ubt_pkg::SLOT_W) ? CW : ubt_pkg::SLOT_W;

   // Entry memory.
   logic [KEY_BITS-1:0]  key_mem_ff  [CAPACITY];
   logic [DATA_BITS-1:0] data_mem_ff [CAPACITY];
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [DATA_BITS-1:0] rd_data_ff;

   // Captured request.
   logic [ubt_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   logic [DATA_BITS-1:0]       data_ff, data_in;
   logic [ubt_pkg::SLOT_W-1:0] slot_ff, slot_in;

   // Table bookkeeping.
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;

   // Pending result and output register.
   ubt_pkg::ubt_rsp_type res_ff, res_in;
   ubt_pkg::ubt_rsp_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [KEY_BITS-1:0]  wr_key;
   logic [DATA_BITS-1:0] wr_data;
   logic [CW-1:0]        idx_inc;
   logic [AW-1:0]        slot_addr, last_addr;

   assign idx_inc   = CW'(idx_ff) + CW'(1);
   assign slot_addr = AW'(slot_ff);
   assign last_addr = AW'(count_ff - CW'(1));

   // Status back to the controller.
   always_comb begin
      stat.is_add    = (mode_ff == ubt_pkg::MODE_ADD);
      stat.is_find   = (mode_ff == ubt_pkg::MODE_FIND);
      stat.is_delete = (mode_ff == ubt_pkg::MODE_DELETE);
      stat.is_clear  = (mode_ff == ubt_pkg::MODE_CLEAR);
      stat.is_read   = (mode_ff == ubt_pkg::MODE_READ);
      stat.full      = (count_ff >= CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.slot_bad  = (CMPW'(slot_ff) >= CMPW'(count_ff));
      stat.scan_hit  = (rd_key_ff == key_ff);
      stat.scan_last = (idx_inc >= count_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection. An add writes the request at the tail; a delete
   // writes the fetched tail entry into the freed slot.
   always_comb begin
      wr_en   = cmd.add_entry || cmd.move_entry;
      wr_addr = cmd.move_entry ? slot_addr : AW'(count_ff);
      wr_key  = cmd.move_entry ? rd_key_ff : key_ff;
      wr_data = cmd.move_entry ? rd_data_ff : data_ff;
      rd_en   = cmd.scan_start || cmd.scan_step || cmd.fetch_last || cmd.fetch_slot;
      priority if (cmd.scan_start) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = AW'(idx_inc);
      end else if (cmd.fetch_last) begin
         rd_addr = last_addr;
      end else begin
         rd_addr = slot_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr]  <= wr_key;
         data_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_key_ff  <= key_mem_ff[rd_addr];
         rd_data_ff <= data_mem_ff[rd_addr];
      end
   end

   // Next values of the request, count, index and result registers.
   always_comb begin
      mode_in      = mode_ff;
      key_in       = key_ff;
      data_in      = data_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.capture) begin
         mode_in = req_payload.mode;
         key_in  = KEY_BITS'(req_payload.key_in);
         data_in = DATA_BITS'(req_payload.data_in);
         slot_in = req_payload.slot_in;
      end

      if (cmd.add_entry) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.move_entry) begin
         count_in = count_ff - CW'(1);
      end else if (cmd.clear_all) begin
         count_in = '0;
      end

      if (cmd.scan_start) begin
         idx_in = '0;
      end else if (cmd.scan_step) begin
         idx_in = AW'(idx_inc);
      end

      if (cmd.set_res) begin
         res_in = '0;
         unique case (cmd.res_kind)
            ubt_pkg::RES_CLEAN: res_in.status = ubt_pkg::STATUS_OK;
            ubt_pkg::RES_ADD: begin
               res_in.status   = ubt_pkg::STATUS_OK;
               res_in.slot_out = ubt_pkg::SLOT_W'(count_ff);
            end
            ubt_pkg::RES_FULL: res_in.status = ubt_pkg::STATUS_FULL;
            ubt_pkg::RES_MISS: res_in.status = ubt_pkg::STATUS_MISS;
            ubt_pkg::RES_BAD:  res_in.status = ubt_pkg::STATUS_BAD_SLOT;
            ubt_pkg::RES_HIT: begin
               res_in.status   = ubt_pkg::STATUS_OK;
               res_in.slot_out = ubt_pkg::SLOT_W'(idx_ff);
               res_in.key_out  = ubt_pkg::FIELD_W'(rd_key_ff);
               res_in.data_out = ubt_pkg::FIELD_W'(rd_data_ff);
            end
            ubt_pkg::RES_READ: begin
               res_in.status   = ubt_pkg::STATUS_OK;
               res_in.slot_out = slot_ff;
               res_in.key_out  = ubt_pkg::FIELD_W'(rd_key_ff);
               res_in.data_out = ubt_pkg::FIELD_W'(rd_data_ff);
            end
            default: res_in.status = ubt_pkg::STATUS_OK;
         endcase
      end

      // The output register takes the result with the count as it stands after the operation.
      if (cmd.load_rsp) begin
         rsp_in             = res_ff;
         rsp_in.entry_count = ubt_pkg::COUNT_W'(count_ff);
         rsp_valid_in       = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      key_ff  <= key_in;
      data_ff <= data_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- design/ubt_ctrl.sv -----
// Controller state machine of the unordered bag table.
`default_nettype none

module ubt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  ubt_pkg::ubt_stat_type stat,
   output ubt_pkg::ubt_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_FINISH = 5'b10000
   } ubt_state_type;

   ubt_state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Sequencing of one item through the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            priority if (stat.is_add) begin
               cmd.set_res = 1'b1;
               if (stat.full) begin
                  cmd.res_kind = ubt_pkg::RES_FULL;
               end else begin
                  cmd.add_entry = 1'b1;
                  cmd.res_kind  = ubt_pkg::RES_ADD;
               end
            end else if (stat.is_find) begin
               if (stat.empty) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_kind = ubt_pkg::RES_MISS;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end else if (stat.is_delete || stat.is_read) begin
               if (stat.slot_bad) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_kind = ubt_pkg::RES_BAD;
               end else begin
                  cmd.fetch_last = stat.is_delete;
                  cmd.fetch_slot = stat.is_read;
                  state_in       = ST_FETCH;
               end
            end else if (stat.is_clear) begin
               cmd.clear_all = 1'b1;
               cmd.set_res   = 1'b1;
               cmd.res_kind  = ubt_pkg::RES_CLEAN;
            end else begin
               cmd.set_res  = 1'b1;
               cmd.res_kind = ubt_pkg::RES_CLEAN;
            end
         end
         ST_SCAN: begin
            // The entry read last cycle is compared while the next one is read, unless it hits or is the last.
            priority if (stat.scan_hit) begin
               cmd.set_res  = 1'b1;
               cmd.res_kind = ubt_pkg::RES_HIT;
               state_in     = ST_FINISH;
            end else if (stat.scan_last) begin
               cmd.set_res  = 1'b1;
               cmd.res_kind = ubt_pkg::RES_MISS;
               state_in     = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.set_res = 1'b1;
            if (stat.is_delete) begin
               cmd.move_entry = 1'b1;
               cmd.res_kind   = ubt_pkg::RES_CLEAN;
            end else begin
               cmd.res_kind = ubt_pkg::RES_READ;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- verif/tb_unordered_bag_table_unit.sv -----
// Self-checking testbench for the unordered bag table: directed and random operations.
`default_nettype none

module tb_unordered_bag_table_unit;

   localparam int RANDOM_ITEMS = 1300;
   localparam int QUIET_TAIL   = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   // Mirror of the table that predicts each result from the accepted items.
   class bag_scoreboard;
      logic [ubt_pkg::FIELD_W-1:0] key_mem[ubt_pkg::CAPACITY_DEF];
      logic [ubt_pkg::FIELD_W-1:0] data_mem[ubt_pkg::CAPACITY_DEF];
      int unsigned                 used;
      ubt_pkg::ubt_rsp_type        bag_results[$];
      int                          failures;

      function new();
         used     = 0;
         failures = 0;
         foreach (key_mem[i]) begin
            key_mem[i]  = '0;
            data_mem[i] = '0;
         end
      endfunction

      function int pending();
         return bag_results.size();
      endfunction

      // Apply one accepted operation to the mirror and queue its result.
      function void apply_operation(ubt_pkg::ubt_req_type item);
         ubt_pkg::ubt_rsp_type r;
         int unsigned          s;
         bit                   hit;
         r   = '0;
         s   = item.slot_in;
         hit = 1'b0;
         case (item.mode)
            ubt_pkg::MODE_ADD: begin
               if (used >= ubt_pkg::CAPACITY_DEF) begin
                  r.status = ubt_pkg::STATUS_FULL;
               end else begin
                  key_mem[used]  = item.key_in;
                  data_mem[used] = item.data_in;
                  r.slot_out     = ubt_pkg::SLOT_W'(used);
                  used++;
               end
            end
            ubt_pkg::MODE_FIND: begin
               // The first matching slot from the bottom wins.
               for (int i = 0; i < used; i++) begin
                  if (!hit && key_mem[i] == item.key_in) begin
                     hit        = 1'b1;
                     r.slot_out = ubt_pkg::SLOT_W'(i);
                     r.key_out  = key_mem[i];
                     r.data_out = data_mem[i];
                  end
               end
               if (!hit) begin
                  r.status = ubt_pkg::STATUS_MISS;
               end
            end
            ubt_pkg::MODE_DELETE: begin
               if (s >= used) begin
                  r.status = ubt_pkg::STATUS_BAD_SLOT;
               end else begin
                  // The tail entry fills the hole unless the hole is the tail.
                  if (s != used - 1) begin
                     key_mem[s]  = key_mem[used-1];
                     data_mem[s] = data_mem[used-1];
                  end
                  used--;
               end
            end
            ubt_pkg::MODE_CLEAR: begin
               used = 0;
            end
            ubt_pkg::MODE_READ: begin
               if (s >= used) begin
                  r.status = ubt_pkg::STATUS_BAD_SLOT;
               end else begin
                  r.slot_out = item.slot_in;
                  r.key_out  = key_mem[s];
                  r.data_out = data_mem[s];
               end
            end
            default: begin
            end
         endcase
         r.entry_count = ubt_pkg::COUNT_W'(used);
         bag_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [ubt_pkg::FIELD_W-1:0] want,
                                  logic [ubt_pkg::FIELD_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            failures++;
         end
      endfunction

      // Compare one result item with the oldest prediction.
      function void check_result(ubt_pkg::ubt_rsp_type got);
         ubt_pkg::ubt_rsp_type want;
         if (bag_results.size() == 0) begin
            $error("result item with no request outstanding: %h", got);
            failures++;
            return;
         end
         want = bag_results.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("slot_out", want.slot_out, got.slot_out);
         compare_field("key_out", want.key_out, got.key_out);
         compare_field("data_out", want.data_out, got.data_out);
         compare_field("entry_count", want.entry_count, got.entry_count);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ubt_pkg::ubt_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ubt_pkg::ubt_rsp_type rsp_payload;

   bit sender_idles = 1'b0;
   bit sink_idles   = 1'b0;
   int quiet_cycles = 0;

   bag_scoreboard sb = new();

   unordered_bag_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Check every result item at the edge where it is accepted.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_payload);
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL unordered_bag_table_unit");
         $finish;
      end
   end

   // Result side: ready drops in short random bursts while idling is on.
   initial begin : sink_side
      int stall;
      @(posedge clock);
      forever begin
         if (sink_idles && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   function automatic ubt_pkg::ubt_req_type pack_request(
         logic [ubt_pkg::MODE_W-1:0] mode,
         logic [ubt_pkg::FIELD_W-1:0] key,
         logic [ubt_pkg::FIELD_W-1:0] data,
         logic [ubt_pkg::SLOT_W-1:0] slot);
      ubt_pkg::ubt_req_type item;
      item.mode    = mode;
      item.key_in  = key;
      item.data_in = data;
      item.slot_in = slot;
      return item;
   endfunction

   // Keys mix a small pool (to make duplicates), the extremes and full range.
   function automatic logic [ubt_pkg::FIELD_W-1:0] random_key();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return ubt_pkg::FIELD_W'($urandom_range(0, 7));
      if (pick == 3) return '1;
      if (pick == 4) return '0;
      return $urandom;
   endfunction

   // Build a random operation, steered toward filling or draining the table.
   function automatic ubt_pkg::ubt_req_type random_request(bit drain_bias);
      ubt_pkg::ubt_req_type item;
      int                   roll;
      int                   add_top;
      int                   find_top;
      item.mode    = ubt_pkg::MODE_W'($urandom_range(0, 7));
      item.key_in  = $urandom;
      item.data_in = $urandom;
      item.slot_in = ubt_pkg::SLOT_W'($urandom_range(0, 15));
      roll     = $urandom_range(0, 99);
      add_top  = drain_bias ? 15 : 45;
      find_top = add_top + 20;
      if (roll < add_top) begin
         item.mode   = ubt_pkg::MODE_ADD;
         item.key_in = random_key();
      end else if (roll < find_top) begin
         item.mode = ubt_pkg::MODE_FIND;
         if (sb.used > 0 && $urandom_range(0, 9) < 6) begin
            item.key_in = sb.key_mem[$urandom_range(0, sb.used - 1)];
         end else begin
            item.key_in = random_key();
         end
      end else if (roll < 75) begin
         item.mode = ubt_pkg::MODE_DELETE;
         if (sb.used > 0 && $urandom_range(0, 9) < 8) begin
            item.slot_in = ubt_pkg::SLOT_W'($urandom_range(0, sb.used - 1));
         end
      end else if (roll < 93) begin
         item.mode = ubt_pkg::MODE_READ;
         if (sb.used > 0 && $urandom_range(0, 9) < 7) begin
            item.slot_in = ubt_pkg::SLOT_W'($urandom_range(0, sb.used - 1));
         end
      end else if (roll < 95) begin
         item.mode = ubt_pkg::MODE_CLEAR;
      end else begin
         item.mode = ubt_pkg::MODE_W'($urandom_range(5, 7));
      end
      return item;
   endfunction

   // Offer one item, optionally after an idle burst, and note it once accepted.
   task automatic drive_item(ubt_pkg::ubt_req_type item);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.apply_operation(item);
   endtask

   // Hold the request side until every outstanding result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin : stimulus
      bit drain_bias;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, extremes, duplicates, swap on delete.
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
      drive_item(pack_request(ubt_pkg::MODE_CLEAR, '1, '1, '1));
      drive_item(pack_request(ubt_pkg::MODE_READ, '0, '0, 4'd0));
      drive_item(pack_request(ubt_pkg::MODE_DELETE, '0, '0, 4'd0));
      drive_item(pack_request(ubt_pkg::MODE_FIND, '0, '0, '0));
      drive_item(pack_request(ubt_pkg::MODE_ADD, '0, '0, '1));
      drive_item(pack_request(ubt_pkg::MODE_ADD, '1, '1, '0));
      drive_item(pack_request(ubt_pkg::MODE_ADD, 32'h1234_5678, 32'hA5A5_A5A5, '0));
      drive_item(pack_request(ubt_pkg::MODE_ADD, '0, 32'h5A5A_5A5A, '0));
      drive_item(pack_request(ubt_pkg::MODE_FIND, '0, '1, '1));
      drive_item(pack_request(ubt_pkg::MODE_FIND, '1, '0, '0));
      drive_item(pack_request(ubt_pkg::MODE_FIND, 32'hDEAD_BEEF, '0, '0));
      drive_item(pack_request(ubt_pkg::MODE_READ, '0, '0, 4'd3));
      drive_item(pack_request(ubt_pkg::MODE_READ, '1, '1, 4'd15));
      drive_item(pack_request(ubt_pkg::MODE_DELETE, '0, '0, 4'd3));
      drive_item(pack_request(ubt_pkg::MODE_DELETE, '1, '1, 4'd0));
      drive_item(pack_request(ubt_pkg::MODE_READ, '0, '0, 4'd0));
      drive_item(pack_request(ubt_pkg::MODE_FIND, 32'h1234_5678, '0, '0));
      drive_item(pack_request(ubt_pkg::MODE_DELETE, '0, '0, 4'd15));
      drive_item(pack_request(3'd5, '1, '1, '1));
      drive_item(pack_request(3'd6, '0, '0, '0));
      drive_item(pack_request(3'd7, '1, '1, '1));
      drive_item(pack_request(ubt_pkg::MODE_CLEAR, '0, '0, '0));
      drive_item(pack_request(ubt_pkg::MODE_FIND, '0, '0, '0));

      // Random part in blocks of 100 items, each at random biased toward filling or draining.
      drain_bias = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            drain_bias   = $urandom_range(0, 2) == 0;
            sender_idles = $urandom_range(0, 3) != 0;
            sink_idles   = $urandom_range(0, 3) != 0;
         end
         if (i >= RANDOM_ITEMS - QUIET_TAIL) begin
            sender_idles = 1'b0;
            sink_idles   = 1'b0;
         end
         if (i == 400 || i == 900) begin
            wait_for_drain();
         end
         drive_item(random_request(drain_bias));
      end

      // Let every result come back, then report pass or fail.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("PASS unordered_bag_table_unit");
      end else begin
         $display("FAIL unordered_bag_table_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
